@@ hw/rtl/thread_slot_round_robin_scheduler_core_assert.svh @@
// Assertion macros used by the scheduler top level.
`ifndef THREAD_SLOT_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`define THREAD_SLOT_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TSRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler next-cycle check failed");

`endif

@@ hw/rtl/tsrr_pkg.sv @@
// Package: request and response types, codes and control/status structs.
`default_nettype none
package tsrr_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam logic [2:0] KIND_CREATE = 3'd0;
  localparam logic [2:0] KIND_YIELD  = 3'd1;
  localparam logic [2:0] KIND_FINISH = 3'd2;
  localparam logic [2:0] KIND_JOIN   = 3'd3;
  localparam logic [2:0] KIND_GETID  = 3'd4;

  localparam logic [1:0] OUT_OK   = 2'd0;
  localparam logic [1:0] OUT_ERR  = 2'd1;
  localparam logic [1:0] OUT_WAIT = 2'd2;
  localparam logic [1:0] OUT_DONE = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         target_thread;
    logic signed [31:0] exit_code;
  } req_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [3:0]         thread_id;
    logic signed [31:0] exit_value;
  } rsp_t;

  typedef struct packed {
    logic       load_req;
    logic       start_create;
    logic       start_yield;
    logic       step;
    logic       finish_mark;
    logic       create_claim;
    logic       yield_take;
    logic       join_free;
    logic       res_load;
    logic [1:0] res_outcome;
    logic       res_id_scan;
    logic       res_xval_mem;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       target_oor;
    logic       target_alive;
    logic       target_zombie;
    logic       scan_free;
    logic       scan_alive;
    logic       idx_last;
    logic       k_last;
    logic       cur_alive;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/tsrr_datapath.sv @@
// Datapath: slot status bits, exit value memory, scan counters, result registers.
`default_nettype none
module tsrr_datapath
  import tsrr_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  req_t req,
  input  wire  rsp_stall,
  output logic rsp_valid,
  output rsp_t rsp,
  input  cmd_t cmd,
  output sts_t sts
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [SLOT_COUNT-1:0] alive;
  logic [SLOT_COUNT-1:0] zombie;
  logic [SW-1:0]         current;
  logic [SW-1:0]         idx;
  logic [SW-1:0]         k;
  req_t                  req_q;
  rsp_t                  res_q;
  logic [31:0]           exit_mem [SLOT_COUNT];
  logic [31:0]           rd_data;

  logic [SW-1:0]         target_idx;
  logic [SW-1:0]         idx_inc;
  logic [SW-1:0]         cur_inc;
  logic [SW+3:0]         idx_ext;
  logic [SW+3:0]         cur_ext;

  assign target_idx = req_q.target_thread[SW-1:0];
  assign idx_inc    = (idx == SW'(SLOT_COUNT - 1)) ? '0 : idx + 1'b1;
  assign cur_inc    = (current == SW'(SLOT_COUNT - 1)) ? '0 : current + 1'b1;
  assign idx_ext    = {4'b0, idx};
  assign cur_ext    = {4'b0, current};

  always_comb begin
    sts.kind          = req_q.kind;
    sts.target_oor    = {1'b0, req_q.target_thread} >= 9'(SLOT_COUNT);
    sts.target_alive  = alive[target_idx];
    sts.target_zombie = zombie[target_idx];
    sts.scan_free     = !alive[idx] && !zombie[idx];
    sts.scan_alive    = alive[idx];
    sts.idx_last      = idx == SW'(SLOT_COUNT - 1);
    sts.k_last        = k == SW'(SLOT_COUNT - 1);
    sts.cur_alive     = alive[current];
    sts.out_free      = !rsp_valid || !rsp_stall;
  end

  // Slot state, current index and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      alive     <= SLOT_COUNT'(1);
      zombie    <= '0;
      current   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.finish_mark) begin
        alive[current]  <= 1'b0;
        zombie[current] <= 1'b1;
      end
      if (cmd.create_claim) begin
        alive[idx] <= 1'b1;
      end
      if (cmd.yield_take) begin
        current <= idx;
      end
      if (cmd.join_free) begin
        zombie[target_idx] <= 1'b0;
      end
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request, scan counters and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.start_create) begin
      idx <= '0;
      k   <= '0;
    end else if (cmd.start_yield) begin
      idx <= cur_inc;
      k   <= SW'(1);
    end else if (cmd.step) begin
      idx <= idx_inc;
      k   <= k + 1'b1;
    end
    if (cmd.res_load) begin
      res_q.outcome    <= cmd.res_outcome;
      res_q.thread_id  <= cmd.res_id_scan ? idx_ext[3:0] : cur_ext[3:0];
      res_q.exit_value <= cmd.res_xval_mem ? rd_data : 32'sd0;
    end
    if (cmd.push) begin
      rsp <= res_q;
    end
  end

  // Exit value store: write on finish, read at the join target.
  always_ff @(posedge clk) begin
    if (cmd.finish_mark) begin
      exit_mem[current] <= req_q.exit_code;
    end
    rd_data <= exit_mem[target_idx];
  end

endmodule
`default_nettype wire

@@ hw/rtl/tsrr_controller.sv @@
// Controller: request sequencing state machine for the slot scheduler.
`default_nettype none
module tsrr_controller
  import tsrr_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CREATE = 3'd2;
  localparam logic [2:0] S_YIELD  = 3'd3;
  localparam logic [2:0] S_JOIN   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       join_wait;
  logic       join_wait_next;

  assign req_stall = state != S_IDLE;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    join_wait_next = join_wait;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_CREATE: begin
            cmd.start_create = 1'b1;
            state_next       = S_CREATE;
          end
          KIND_YIELD: begin
            cmd.start_yield = 1'b1;
            join_wait_next  = 1'b0;
            state_next      = S_YIELD;
          end
          KIND_FINISH: begin
            cmd.finish_mark = 1'b1;
            cmd.start_yield = 1'b1;
            join_wait_next  = 1'b0;
            state_next      = S_YIELD;
          end
          KIND_JOIN: begin
            if (sts.target_oor || (!sts.target_alive && !sts.target_zombie)) begin
              cmd.res_load    = 1'b1;
              cmd.res_outcome = OUT_ERR;
              state_next      = S_DONE;
            end else if (sts.target_alive) begin
              cmd.start_yield = 1'b1;
              join_wait_next  = 1'b1;
              state_next      = S_YIELD;
            end else begin
              cmd.join_free = 1'b1;
              state_next    = S_JOIN;
            end
          end
          KIND_GETID: begin
            cmd.res_load    = 1'b1;
            cmd.res_outcome = OUT_OK;
            state_next      = S_DONE;
          end
          default: begin
            cmd.res_load    = 1'b1;
            cmd.res_outcome = OUT_ERR;
            state_next      = S_DONE;
          end
        endcase
      end
      S_CREATE: begin
        if (sts.scan_free) begin
          cmd.create_claim = 1'b1;
          cmd.res_load     = 1'b1;
          cmd.res_outcome  = OUT_OK;
          cmd.res_id_scan  = 1'b1;
          state_next       = S_DONE;
        end else if (sts.idx_last) begin
          cmd.res_load    = 1'b1;
          cmd.res_outcome = OUT_ERR;
          state_next      = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_YIELD: begin
        if (sts.scan_alive) begin
          cmd.yield_take  = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_outcome = join_wait ? OUT_WAIT : OUT_OK;
          cmd.res_id_scan = 1'b1;
          state_next      = S_DONE;
        end else if (sts.k_last) begin
          cmd.res_load    = 1'b1;
          cmd.res_outcome = join_wait ? OUT_WAIT : (sts.cur_alive ? OUT_OK : OUT_DONE);
          state_next      = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_JOIN: begin
        cmd.res_load     = 1'b1;
        cmd.res_outcome  = OUT_OK;
        cmd.res_xval_mem = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      join_wait <= 1'b0;
    end else begin
      state     <= state_next;
      join_wait <= join_wait_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/thread_slot_round_robin_scheduler_core.sv @@
// Top level of the round robin thread slot scheduler.
// Sequence: accept, decode, then for create, yield, finish and waiting joins a slot scan (one
// slot per cycle) that loads the result; get id and rejected joins load it at decode, and a
// reaping join loads it in a separate join state that reads the stored exit value.
// One request at a time; the next transfer is taken once the result sits in the output register.
// Synchronous active-high reset: slot 0 alive and current, all other slots unused.
`default_nettype none
`include "thread_slot_round_robin_scheduler_core_assert.svh"
module thread_slot_round_robin_scheduler_core
  import tsrr_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  wire  rsp_stall,
  output rsp_t rsp
);

  // Command and status between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: decode each transfer, run the create or yield scan, hand off the result.
  tsrr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: hold slot status, exit values and the output register.
  tsrr_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

  // A taken request keeps the input stalled in the next cycle while it is served.
  `TSRR_ASSERT_NEXT(a_busy_after_transfer, req_valid && !req_stall, req_stall)
  // Only a successful join carries a nonzero exit value.
  `TSRR_ASSERT_NOW(a_xval_only_on_ok, rsp_valid && (rsp.exit_value != 0), rsp.outcome == OUT_OK)
  // A new result is never loaded while the input side is idle.
  `TSRR_ASSERT_NOW(a_push_needs_request, !req_stall, !cmd.push)

endmodule
`default_nettype wire
